// ===== rtl/core/sfq_pkg.sv =====
// ----------------------------------------------------------------------------
// sfq_pkg
// Command codes, status codes and item types of the searchable FIFO queue.
// ----------------------------------------------------------------------------
`default_nettype none

package sfq_pkg;

   localparam logic [2:0] KIND_PUSH   = 3'd0;
   localparam logic [2:0] KIND_POP    = 3'd1;
   localparam logic [2:0] KIND_READ   = 3'd2;
   localparam logic [2:0] KIND_SEARCH = 3'd3;
   localparam logic [2:0] KIND_TOGGLE = 3'd4;
   localparam logic [2:0] KIND_CLEAR  = 3'd5;

   localparam logic [2:0] ST_OK       = 3'd0;
   localparam logic [2:0] ST_EMPTY    = 3'd1;
   localparam logic [2:0] ST_FULL     = 3'd2;
   localparam logic [2:0] ST_LOCKED   = 3'd3;
   localparam logic [2:0] ST_BADPOS   = 3'd4;
   localparam logic [2:0] ST_NOTFOUND = 3'd5;

   typedef struct packed {
      logic [2:0]         kind;
      logic signed [31:0] value;
      logic [4:0]         position;
   } req_type;

   typedef struct packed {
      logic [2:0]         status;
      logic signed [31:0] data;
      logic [4:0]         where_found;
      logic [4:0]         occupancy;
      logic               circular;
      logic               last;
   } rsp_type;

endpackage

`default_nettype wire

// ===== rtl/core/searchable_fifo_queue_top.sv =====
// ----------------------------------------------------------------------------
// searchable_fifo_queue_top
// Bounded FIFO of signed words with push, pop, positional read, value
// search, circular lock and clear; entries held in one synchronous RAM.
//
//   channel  dir  handshake            payload
//   req_     in   req_valid/req_ready  sfq_pkg::req_type  (one command)
//   rsp_     out  rsp_valid/rsp_ready  sfq_pkg::rsp_type  (1..DEPTH results)
//
// One command at a time; req_ready is high only while the engine is idle.
// Push, toggle, clear and refused commands: result registered at accept and
// offered from S_RESP; pop and read first take the RAM read in S_READ.
// Search: one RAM read per entry through the single read port, final item
// offered from S_RESP after the walk. Next command is accepted once the
// engine is back in S_IDLE after the final item is registered. Output
// register decouples rsp_ready; a stalled item holds the engine and a
// stalled match pauses the walk. Reset is synchronous; entries are not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module searchable_fifo_queue_top #(
   parameter int DEPTH = 16
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_ready,
   input  wire sfq_pkg::req_type req_item,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   output sfq_pkg::rsp_type      rsp_item
);

   localparam int AW = $clog2(DEPTH);

   logic             eng_valid;
   logic             eng_ready;
   sfq_pkg::rsp_type eng_item;
   logic             ram_we;
   logic [AW-1:0]    ram_waddr;
   logic [31:0]      ram_wdata;
   logic [AW-1:0]    ram_raddr;
   logic [31:0]      ram_rdata;

   logic             rsp_valid_ff, rsp_valid_in;
   sfq_pkg::rsp_type rsp_item_ff,  rsp_item_in;

   sfq_ram #(
      .WIDTH (32),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   sfq_engine #(
      .DEPTH (DEPTH)
   ) u_engine (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_item  (req_item),
      .out_valid (eng_valid),
      .out_ready (eng_ready),
      .out_item  (eng_item),
      .ram_we    (ram_we),
      .ram_waddr (ram_waddr),
      .ram_wdata (ram_wdata),
      .ram_raddr (ram_raddr),
      .ram_rdata (ram_rdata)
   );

   assign eng_ready = !rsp_valid_ff || rsp_ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_item_in  = rsp_item_ff;
      if (eng_valid && eng_ready) begin
         rsp_valid_in = 1'b1;
         rsp_item_in  = eng_item;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_item_ff <= rsp_item_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

endmodule

`default_nettype wire

// ===== rtl/core/sfq_ram.sv =====
// ----------------------------------------------------------------------------
// sfq_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module sfq_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== rtl/core/sfq_engine.sv =====
// ----------------------------------------------------------------------------
// sfq_engine
// Command sequencer: head/count/lock registers, RAM addressing and the
// head-to-tail search walk with one-match lookahead for the last flag.
// ----------------------------------------------------------------------------
`default_nettype none

module sfq_engine #(
   parameter int DEPTH = 16
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_valid,
   output logic                             req_ready,
   input  wire sfq_pkg::req_type            req_item,
   output logic                             out_valid,
   input  wire logic                        out_ready,
   output sfq_pkg::rsp_type                 out_item,
   output logic                             ram_we,
   output logic [$clog2(DEPTH)-1:0]         ram_waddr,
   output logic [31:0]                      ram_wdata,
   output logic [$clog2(DEPTH)-1:0]         ram_raddr,
   input  wire logic [31:0]                 ram_rdata
);

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_READ = 2'd1;
   localparam logic [1:0] S_SCAN = 2'd2;
   localparam logic [1:0] S_RESP = 2'd3;

   logic [1:0]       state_ff,    state_in;
   logic [AW-1:0]    head_ff,     head_in;
   logic [CW-1:0]    count_ff,    count_in;
   logic             lock_ff,     lock_in;
   sfq_pkg::rsp_type res_ff,      res_in;
   logic [31:0]      value_ff,    value_in;
   logic [CW-1:0]    nxt_ff,      nxt_in;
   logic             cmp_vld_ff,  cmp_vld_in;
   logic [CW-1:0]    cmp_off_ff,  cmp_off_in;
   logic             pend_vld_ff, pend_vld_in;
   logic [CW-1:0]    pend_off_ff, pend_off_in;

   logic             cmp_hit;
   logic             need_emit;
   logic             lockable;
   sfq_pkg::rsp_type scan_item;

   // head-relative offset to RAM slot; offset is at most DEPTH
   function automatic logic [AW-1:0] slot(input logic [AW-1:0] h, input logic [CW-1:0] off);
      logic [CW:0] sum;
      sum = (CW+1)'(h) + (CW+1)'(off);
      if (sum >= (CW+1)'(DEPTH)) begin
         sum = sum - (CW+1)'(DEPTH);
      end
      return AW'(sum);
   endfunction

   assign cmp_hit   = cmp_vld_ff && (ram_rdata == value_ff);
   assign need_emit = cmp_hit && pend_vld_ff;
   assign lockable  = (req_item.kind inside {sfq_pkg::KIND_PUSH, sfq_pkg::KIND_POP,
                                             sfq_pkg::KIND_READ, sfq_pkg::KIND_SEARCH,
                                             sfq_pkg::KIND_CLEAR});

   always_comb begin
      scan_item.status      = sfq_pkg::ST_OK;
      scan_item.data        = value_ff;
      scan_item.where_found = 5'(pend_off_ff + CW'(1));
      scan_item.occupancy   = 5'(count_ff);
      scan_item.circular    = lock_ff;
      scan_item.last        = 1'b0;
   end

   always_comb begin
      state_in    = state_ff;
      head_in     = head_ff;
      count_in    = count_ff;
      lock_in     = lock_ff;
      res_in      = res_ff;
      value_in    = value_ff;
      nxt_in      = nxt_ff;
      cmp_vld_in  = cmp_vld_ff;
      cmp_off_in  = cmp_off_ff;
      pend_vld_in = pend_vld_ff;
      pend_off_in = pend_off_ff;
      req_ready   = (state_ff == S_IDLE);
      out_valid   = 1'b0;
      out_item    = res_ff;
      ram_we      = 1'b0;
      ram_waddr   = slot(head_ff, count_ff);
      ram_wdata   = req_item.value;
      ram_raddr   = head_ff;

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               value_in           = req_item.value;
               nxt_in             = '0;
               cmp_vld_in         = 1'b0;
               pend_vld_in        = 1'b0;
               state_in           = S_RESP;
               res_in.status      = sfq_pkg::ST_OK;
               res_in.data        = '0;
               res_in.where_found = '0;
               res_in.occupancy   = 5'(count_ff);
               res_in.circular    = lock_ff;
               res_in.last        = 1'b1;
               if (lockable && lock_ff) begin
                  res_in.status = sfq_pkg::ST_LOCKED;
               end else if (lockable && req_item.kind != sfq_pkg::KIND_PUSH &&
                            count_ff == '0) begin
                  res_in.status = sfq_pkg::ST_EMPTY;
               end else begin
                  case (req_item.kind)
                     sfq_pkg::KIND_PUSH: begin
                        if (count_ff == CW'(DEPTH)) begin
                           res_in.status = sfq_pkg::ST_FULL;
                        end else begin
                           ram_we             = 1'b1;
                           count_in           = count_ff + CW'(1);
                           res_in.data        = req_item.value;
                           res_in.where_found = 5'(count_ff + CW'(1));
                           res_in.occupancy   = 5'(count_ff + CW'(1));
                        end
                     end
                     sfq_pkg::KIND_POP: begin
                        ram_raddr          = head_ff;
                        count_in           = count_ff - CW'(1);
                        head_in            = (count_ff == CW'(1)) ? '0 : slot(head_ff, CW'(1));
                        res_in.where_found = 5'd1;
                        res_in.occupancy   = 5'(count_ff - CW'(1));
                        state_in           = S_READ;
                     end
                     sfq_pkg::KIND_READ: begin
                        if (req_item.position == 5'd0 ||
                            int'(req_item.position) > int'(count_ff)) begin
                           res_in.status = sfq_pkg::ST_BADPOS;
                        end else begin
                           ram_raddr          = slot(head_ff, CW'(req_item.position - 5'd1));
                           res_in.where_found = req_item.position;
                           state_in           = S_READ;
                        end
                     end
                     sfq_pkg::KIND_SEARCH: begin
                        state_in = S_SCAN;
                     end
                     sfq_pkg::KIND_TOGGLE: begin
                        if (!lock_ff && count_ff == '0) begin
                           res_in.status = sfq_pkg::ST_EMPTY;
                        end else begin
                           lock_in         = !lock_ff;
                           res_in.circular = !lock_ff;
                        end
                     end
                     sfq_pkg::KIND_CLEAR: begin
                        count_in         = '0;
                        head_in          = '0;
                        res_in.occupancy = '0;
                     end
                     default: begin
                     end
                  endcase
               end
            end
         end
         S_READ: begin
            res_in.data = ram_rdata;
            state_in    = S_RESP;
         end
         S_SCAN: begin
            out_valid = need_emit;
            out_item  = scan_item;
            if (!cmp_vld_ff && nxt_ff == count_ff) begin
               res_in.occupancy = 5'(count_ff);
               res_in.circular  = lock_ff;
               res_in.last      = 1'b1;
               if (pend_vld_ff) begin
                  res_in.status      = sfq_pkg::ST_OK;
                  res_in.data        = value_ff;
                  res_in.where_found = 5'(pend_off_ff + CW'(1));
               end else begin
                  res_in.status      = sfq_pkg::ST_NOTFOUND;
                  res_in.data        = '0;
                  res_in.where_found = '0;
               end
               state_in = S_RESP;
            end else if (need_emit && !out_ready) begin
               // hold: re-read the entry under compare
               ram_raddr = slot(head_ff, cmp_off_ff);
            end else begin
               if (cmp_hit) begin
                  pend_vld_in = 1'b1;
                  pend_off_in = cmp_off_ff;
               end
               if (nxt_ff != count_ff) begin
                  ram_raddr  = slot(head_ff, nxt_ff);
                  cmp_vld_in = 1'b1;
                  cmp_off_in = nxt_ff;
                  nxt_in     = nxt_ff + CW'(1);
               end else begin
                  cmp_vld_in = 1'b0;
               end
            end
         end
         S_RESP: begin
            out_valid = 1'b1;
            out_item  = res_ff;
            if (out_ready) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_IDLE;
         head_ff     <= '0;
         count_ff    <= '0;
         lock_ff     <= 1'b0;
         cmp_vld_ff  <= 1'b0;
         pend_vld_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         head_ff     <= head_in;
         count_ff    <= count_in;
         lock_ff     <= lock_in;
         cmp_vld_ff  <= cmp_vld_in;
         pend_vld_ff <= pend_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      res_ff      <= res_in;
      value_ff    <= value_in;
      nxt_ff      <= nxt_in;
      cmp_off_ff  <= cmp_off_in;
      pend_off_ff <= pend_off_in;
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(DEPTH))
      else $error("entry count above depth");

   a_write_room: assert property (@(posedge clock) disable iff (reset)
      ram_we |-> (count_ff < CW'(DEPTH)) && !lock_ff)
      else $error("write into full or locked queue");

   a_empty_head: assert property (@(posedge clock) disable iff (reset)
      (count_ff == '0) |-> (head_ff == '0))
      else $error("head not home on empty queue");

   a_scan_unlocked: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SCAN) |-> !lock_ff && (count_ff != '0))
      else $error("search on locked or empty queue");

   a_scan_not_last: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SCAN && out_valid) |-> !out_item.last && pend_vld_ff)
      else $error("search match item marked last");

endmodule

`default_nettype wire

// ===== bench/searchable_fifo_queue_top_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// searchable_fifo_queue_top_tb
// Self-checking bench for the searchable FIFO queue. A queue of commands
// feeds a valid/ready driver. Each accepted command updates a shadow copy of
// the queue, which predicts every result. A monitor compares each result,
// field by field, against the oldest prediction. Both sides insert random
// idle cycles, with calm stretches between them.
// ----------------------------------------------------------------------------

module searchable_fifo_queue_top_tb;

   localparam int QUEUE_DEPTH  = 16;
   localparam int RANDOM_ITEMS = 90;
   localparam int DRAIN_CYCLES = 40;

   typedef struct {
      sfq_pkg::req_type cmd;
      int unsigned      idle;
   } queued_cmd_type;

   logic             clock;
   logic             reset     = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_ready;
   sfq_pkg::req_type req_item  = '0;
   logic             rsp_valid;
   logic             rsp_ready = 1'b0;
   sfq_pkg::rsp_type rsp_item;

   queued_cmd_type   cmd_backlog[$];
   sfq_pkg::rsp_type results_due[$];

   logic signed [31:0] shadow_words[QUEUE_DEPTH];
   int unsigned        shadow_head     = 0;
   int unsigned        shadow_count    = 0;
   logic               shadow_locked   = 1'b0;

   int unsigned commands_sent   = 0;
   int unsigned results_checked = 0;
   int unsigned search_hits     = 0;
   int unsigned locked_refusals = 0;
   int unsigned mismatches      = 0;

   bit          feed_calm       = 1'b0;
   bit          drain_calm      = 1'b1;
   int unsigned drain_phase     = 0;
   int unsigned drain_hold      = 0;

   searchable_fifo_queue_top #(
      .DEPTH(QUEUE_DEPTH)
   ) dut (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_item (req_item),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_item (rsp_item)
   );

   always begin
      clock = 1'b0;
      #6;
      clock = 1'b1;
      #6;
   end

   function automatic int unsigned idle_len();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (roll < 55) return 0;
      if (roll < 85) return $urandom_range(1, 3);
      if (roll < 96) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // shadow queue: applies one command and queues the results it causes
   task automatic predict_queue_results(input sfq_pkg::req_type cmd);
      sfq_pkg::rsp_type r;
      int unsigned      hit_at;
      int unsigned      k;
      logic             guarded;
      r        = '0;
      r.status = sfq_pkg::ST_OK;
      r.last   = 1'b1;
      guarded  = (cmd.kind <= sfq_pkg::KIND_SEARCH) || (cmd.kind == sfq_pkg::KIND_CLEAR);
      if (guarded && shadow_locked) begin
         r.status = sfq_pkg::ST_LOCKED;
         locked_refusals++;
      end else if (guarded && cmd.kind != sfq_pkg::KIND_PUSH && shadow_count == 0) begin
         r.status = sfq_pkg::ST_EMPTY;
      end else begin
         case (cmd.kind)
            sfq_pkg::KIND_PUSH: begin
               if (shadow_count >= QUEUE_DEPTH) begin
                  r.status = sfq_pkg::ST_FULL;
               end else begin
                  shadow_words[(shadow_head + shadow_count) % QUEUE_DEPTH] = cmd.value;
                  shadow_count++;
                  r.data        = cmd.value;
                  r.where_found = 5'(shadow_count);
               end
            end
            sfq_pkg::KIND_POP: begin
               r.data        = shadow_words[shadow_head];
               r.where_found = 5'd1;
               shadow_head   = (shadow_head + 1) % QUEUE_DEPTH;
               shadow_count--;
               if (shadow_count == 0) shadow_head = 0;
            end
            sfq_pkg::KIND_READ: begin
               if (cmd.position == 0 || cmd.position > shadow_count) begin
                  r.status = sfq_pkg::ST_BADPOS;
               end else begin
                  r.data        = shadow_words[(shadow_head + cmd.position - 1) % QUEUE_DEPTH];
                  r.where_found = cmd.position;
               end
            end
            sfq_pkg::KIND_SEARCH: begin
               hit_at = 0;
               for (k = 0; k < shadow_count; k++) begin
                  if (shadow_words[(shadow_head + k) % QUEUE_DEPTH] == cmd.value) hit_at = k + 1;
               end
               if (hit_at == 0) begin
                  r.status = sfq_pkg::ST_NOTFOUND;
               end else begin
                  r.data      = cmd.value;
                  r.occupancy = 5'(shadow_count);
                  r.circular  = shadow_locked;
                  for (k = 0; k < shadow_count; k++) begin
                     if (shadow_words[(shadow_head + k) % QUEUE_DEPTH] == cmd.value) begin
                        r.where_found = 5'(k + 1);
                        r.last        = (k + 1 == hit_at);
                        results_due.push_back(r);
                        search_hits++;
                     end
                  end
                  return;
               end
            end
            sfq_pkg::KIND_TOGGLE: begin
               if (!shadow_locked && shadow_count == 0) r.status = sfq_pkg::ST_EMPTY;
               else shadow_locked = ~shadow_locked;
            end
            sfq_pkg::KIND_CLEAR: begin
               shadow_count = 0;
               shadow_head  = 0;
            end
            default: begin
            end
         endcase
      end
      r.occupancy = 5'(shadow_count);
      r.circular  = shadow_locked;
      results_due.push_back(r);
   endtask

   task automatic compare_field(input string name, input logic [31:0] want,
                                input logic [31:0] got);
      if (got !== want) begin
         $error("%s: expected %0h, got %0h", name, want, got);
         mismatches++;
      end
   endtask

   task automatic check_result(input sfq_pkg::rsp_type got);
      sfq_pkg::rsp_type want;
      if (results_due.size() == 0) begin
         $error("result with nothing expected: status %0d data %0h", got.status, got.data);
         mismatches++;
      end else begin
         want = results_due.pop_front();
         compare_field("status", 32'(want.status), 32'(got.status));
         compare_field("data", want.data, got.data);
         compare_field("where_found", 32'(want.where_found), 32'(got.where_found));
         compare_field("occupancy", 32'(want.occupancy), 32'(got.occupancy));
         compare_field("circular", 32'(want.circular), 32'(got.circular));
         compare_field("last", 32'(want.last), 32'(got.last));
         results_checked++;
      end
   endtask

   task automatic add_cmd(input logic [2:0] kind, input logic signed [31:0] value,
                          input logic [4:0] position);
      queued_cmd_type q;
      q.cmd.kind     = kind;
      q.cmd.value    = value;
      q.cmd.position = position;
      q.idle         = feed_calm ? 0 : idle_len();
      cmd_backlog.push_back(q);
   endtask

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            predict_queue_results(req_item);
            commands_sent++;
         end
         if (!req_valid || req_ready) begin
            if (cmd_backlog.size() == 0) begin
               req_valid <= 1'b0;
            end else if (cmd_backlog[0].idle > 0) begin
               cmd_backlog[0].idle = cmd_backlog[0].idle - 1;
               req_valid <= 1'b0;
            end else begin
               req_item  <= cmd_backlog[0].cmd;
               req_valid <= 1'b1;
               void'(cmd_backlog.pop_front());
            end
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) check_result(rsp_item);
         if (drain_phase == 0) begin
            drain_calm  = ($urandom_range(0, 2) == 0);
            drain_phase = $urandom_range(50, 300);
         end else begin
            drain_phase--;
         end
         if (drain_calm) begin
            rsp_ready <= 1'b1;
         end else if (drain_hold > 0) begin
            drain_hold--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
            if ($urandom_range(0, 9) < 3) drain_hold = idle_len();
         end
      end
   end

   // stimulus and end of run
   initial begin
      logic signed [31:0] pool[4];
      int unsigned        random_count;
      int unsigned        fill;
      int unsigned        n;
      int unsigned        k;
      int unsigned        roll;
      logic [2:0]         kind;

      // empty-queue refusals
      add_cmd(sfq_pkg::KIND_POP, 32'sd0, 5'd0);
      add_cmd(sfq_pkg::KIND_READ, 32'sd0, 5'd1);
      add_cmd(sfq_pkg::KIND_SEARCH, 32'sd0, 5'd0);
      add_cmd(sfq_pkg::KIND_CLEAR, 32'sd0, 5'd0);
      add_cmd(sfq_pkg::KIND_TOGGLE, 32'sd0, 5'd0);
      // extremes and a duplicate
      add_cmd(sfq_pkg::KIND_PUSH, 32'sh7FFFFFFF, 5'd0);
      add_cmd(sfq_pkg::KIND_PUSH, 32'sh80000000, 5'd31);
      add_cmd(sfq_pkg::KIND_PUSH, -32'sd1, 5'd16);
      add_cmd(sfq_pkg::KIND_PUSH, 32'sd0, 5'd0);
      add_cmd(sfq_pkg::KIND_PUSH, 32'sh7FFFFFFF, 5'd0);
      add_cmd(sfq_pkg::KIND_READ, 32'sd0, 5'd0);
      add_cmd(sfq_pkg::KIND_READ, 32'sd0, 5'd31);
      add_cmd(sfq_pkg::KIND_READ, 32'sd0, 5'd5);
      add_cmd(sfq_pkg::KIND_READ, 32'sd0, 5'd6);
      add_cmd(sfq_pkg::KIND_SEARCH, 32'sh7FFFFFFF, 5'd0);
      add_cmd(sfq_pkg::KIND_SEARCH, 32'sd12345, 5'd0);
      // circular lock refuses push, pop, read, search and clear
      add_cmd(sfq_pkg::KIND_TOGGLE, 32'sd0, 5'd0);
      add_cmd(sfq_pkg::KIND_PUSH, 32'sd1, 5'd0);
      add_cmd(sfq_pkg::KIND_POP, 32'sd0, 5'd0);
      add_cmd(sfq_pkg::KIND_READ, 32'sd0, 5'd1);
      add_cmd(sfq_pkg::KIND_SEARCH, -32'sd1, 5'd0);
      add_cmd(sfq_pkg::KIND_CLEAR, 32'sd0, 5'd0);
      add_cmd(3'd6, -32'sd1, 5'd31);
      add_cmd(3'd7, 32'sh55AA55AA, 5'd16);
      add_cmd(sfq_pkg::KIND_TOGGLE, 32'sd0, 5'd0);
      add_cmd(sfq_pkg::KIND_POP, 32'sd0, 5'd0);
      add_cmd(sfq_pkg::KIND_CLEAR, 32'sd0, 5'd0);

      random_count = 0;
      while (random_count < RANDOM_ITEMS) begin
         feed_calm = ($urandom_range(0, 3) == 0);
         for (k = 0; k < 4; k++) pool[k] = $urandom();
         if ($urandom_range(0, 3) == 0) pool[0] = 32'sh80000000;
         if ($urandom_range(0, 3) == 0) pool[1] = 32'sh7FFFFFFF;
         roll = $urandom_range(0, 99);
         if (roll < 75) begin
            // well-formed session: clear, fill from a small pool, then work on it
            fill = ($urandom_range(0, 6) == 0) ? QUEUE_DEPTH : $urandom_range(1, 8);
            add_cmd(sfq_pkg::KIND_CLEAR, $urandom(), 5'($urandom_range(0, 31)));
            for (k = 0; k < fill; k++)
               add_cmd(sfq_pkg::KIND_PUSH, pool[$urandom_range(0, 3)],
                       5'($urandom_range(0, 31)));
            if (fill == QUEUE_DEPTH) add_cmd(sfq_pkg::KIND_PUSH, $urandom(), 5'd0);
            random_count += fill + 1;
            n = fill;
            repeat ($urandom_range(2, 7)) begin
               roll = $urandom_range(0, 99);
               if (roll < 35) begin
                  add_cmd(sfq_pkg::KIND_READ, $urandom(),
                          ($urandom_range(0, 4) == 0 || n == 0) ?
                          5'($urandom_range(0, 31)) : 5'($urandom_range(1, n)));
               end else if (roll < 65) begin
                  add_cmd(sfq_pkg::KIND_SEARCH, ($urandom_range(0, 4) == 0) ? $urandom() :
                          pool[$urandom_range(0, 3)], 5'($urandom_range(0, 31)));
               end else if (roll < 85) begin
                  add_cmd(sfq_pkg::KIND_POP, $urandom(), 5'($urandom_range(0, 31)));
                  if (n > 0) n--;
               end else begin
                  add_cmd(sfq_pkg::KIND_PUSH, pool[$urandom_range(0, 3)],
                          5'($urandom_range(0, 31)));
                  if (n < QUEUE_DEPTH) n++;
               end
               random_count++;
            end
            if (n > 0 && $urandom_range(0, 3) == 0) begin
               add_cmd(sfq_pkg::KIND_TOGGLE, $urandom(), 5'($urandom_range(0, 31)));
               repeat ($urandom_range(1, 4)) begin
                  do kind = 3'($urandom_range(0, 7)); while (kind == sfq_pkg::KIND_TOGGLE);
                  add_cmd(kind, pool[$urandom_range(0, 3)], 5'($urandom_range(0, 31)));
                  if (kind <= sfq_pkg::KIND_CLEAR) random_count++;
               end
               add_cmd(sfq_pkg::KIND_TOGGLE, $urandom(), 5'($urandom_range(0, 31)));
               random_count += 2;
            end
         end else begin
            // noise, toggle left out so the lock stays tracked
            repeat ($urandom_range(3, 6)) begin
               do kind = 3'($urandom_range(0, 7)); while (kind == sfq_pkg::KIND_TOGGLE);
               add_cmd(kind, ($urandom_range(0, 1) == 0) ? $urandom() :
                       pool[$urandom_range(0, 3)], 5'($urandom_range(0, 31)));
               if (kind <= sfq_pkg::KIND_CLEAR) random_count++;
            end
         end
      end

      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      while (cmd_backlog.size() != 0 || req_valid) @(posedge clock);
      while (results_due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("run: %0d commands, %0d results checked", commands_sent, results_checked);
      $display("run: %0d search matches, %0d refused while locked", search_hits,
               locked_refusals);
      if (mismatches == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

   initial begin
      #10_000_000;
      $display("simulation failed");
      $finish;
   end

endmodule

// ===== searchable_fifo_queue_top.f =====
rtl/core/sfq_pkg.sv
rtl/core/sfq_ram.sv
rtl/core/sfq_engine.sv
rtl/core/searchable_fifo_queue_top.sv
bench/searchable_fifo_queue_top_tb.sv
